/* src/ihs_pkg.sv */
`timescale 1ns / 1ps

package ihs_pkg;

   // Width of the internal byte counter; it saturates at all ones
   localparam int COUNT_BITS = 32;

   // Counter view widened so the 32-bit output saturation works for any COUNT_BITS
   localparam int WIDE_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;

   // Result format codes
   typedef enum logic [2:0] {
      FMT_UNKNOWN = 3'd0,
      FMT_PNG     = 3'd1,
      FMT_JPEG    = 3'd2,
      FMT_GIF     = 3'd3,
      FMT_BMP     = 3'd4
   } fmt_type;

   // PNG signature byte at a given offset within the first eight bytes
   function automatic logic [7:0] png_sig(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0:    val = 8'h89;
         3'd1:    val = 8'h50;
         3'd2:    val = 8'h4E;
         3'd3:    val = 8'h47;
         3'd4:    val = 8'h0D;
         3'd5:    val = 8'h0A;
         3'd6:    val = 8'h1A;
         default: val = 8'h0A;
      endcase
      return val;
   endfunction

   // GIF signature byte; offset 4 is checked separately (7 or 9)
   function automatic logic [7:0] gif_sig(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0:    val = 8'h47;
         3'd1:    val = 8'h49;
         3'd2:    val = 8'h46;
         3'd3:    val = 8'h38;
         3'd4:    val = 8'h37;
         default: val = 8'h61;
      endcase
      return val;
   endfunction

   // IHDR chunk tag byte
   function automatic logic [7:0] ihdr_tag(input logic [1:0] idx);
      logic [7:0] val;
      unique case (idx)
         2'd0:    val = 8'h49;
         2'd1:    val = 8'h48;
         2'd2:    val = 8'h44;
         default: val = 8'h52;
      endcase
      return val;
   endfunction

   // OR one byte into a 32-bit accumulator at byte lane 0..3
   function automatic logic [31:0] lane_or(input logic [31:0] acc, input logic [1:0] lane,
                                           input logic [7:0] b);
      return acc | (32'(b) << {lane, 3'b000});
   endfunction

endpackage

/* src/image_header_sniffer.sv */
`timescale 1ns / 1ps

// The result is registered: a word carrying last raises rsp_valid in the cycle after its acceptance.
// Throughput: one word per cycle while req_stall is low; each byte needs only compares and a counter step.
// req_stall is raised only while a finished result waits on rsp_stall.
// Reset (synchronous, active high) clears all parse state and drops rsp_valid;
// parse state also returns to its reset values after every word carrying last.
module image_header_sniffer
   import ihs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_has_byte,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_format_code,
   output logic               rsp_recognized,
   output logic signed [31:0] rsp_image_width,
   output logic signed [31:0] rsp_image_height,
   output logic [31:0]        rsp_byte_total
);

   typedef enum logic [3:0] {
      WK_MARK0 = 4'd0,
      WK_MARK1 = 4'd1,
      WK_LEN0  = 4'd2,
      WK_LEN1  = 4'd3,
      WK_SKIP  = 4'd4,
      WK_SLEN0 = 4'd5,
      WK_SLEN1 = 4'd6,
      WK_PREC  = 4'd7,
      WK_H0    = 4'd8,
      WK_H1    = 4'd9,
      WK_W0    = 4'd10,
      WK_W1    = 4'd11,
      WK_STOP  = 4'd12
   } walk_type;

   // Parse state
   logic [COUNT_BITS-1:0] pos_ff,    pos_in;
   fmt_type               guess_ff,  guess_in;
   logic                  magic_ff,  magic_in;
   logic                  tag_ok_ff, tag_ok_in;
   logic [31:0]           wacc_ff,   wacc_in;
   logic [31:0]           hacc_ff,   hacc_in;
   walk_type              phase_ff,  phase_in;
   logic [15:0]           seg_ff,    seg_in;
   logic                  dims_ff,   dims_in;
   logic [7:0]            len_hi_ff, len_hi_in;

   // Result register
   logic                  rsp_valid_ff;
   logic [2:0]            fmt_ff;
   logic                  recog_ff;
   logic [31:0]           width_ff;
   logic [31:0]           height_ff;
   logic [31:0]           total_ff;

   logic                  req_accept;
   logic [7:0]            b;
   logic                  pos_small;
   logic [4:0]            lo;
   logic [15:0]           seg_len;
   fmt_type               fmt_res;
   logic [31:0]           w_res;
   logic [31:0]           h_res;
   logic [WIDE_BITS-1:0]  pos_wide;
   logic [31:0]           total_res;

   // Stall input only while a result is held
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign b         = req_data_byte;
   assign pos_small = (pos_ff < COUNT_BITS'(32));
   assign lo        = pos_ff[4:0];
   assign seg_len   = {len_hi_ff, b};

   // Advance parse state by one byte
   always_comb begin
      pos_in    = pos_ff;
      guess_in  = guess_ff;
      magic_in  = magic_ff;
      tag_ok_in = tag_ok_ff;
      wacc_in   = wacc_ff;
      hacc_in   = hacc_ff;
      phase_in  = phase_ff;
      seg_in    = seg_ff;
      dims_in   = dims_ff;
      len_hi_in = len_hi_ff;

      if (req_has_byte) begin
         // Signature checks over the first eight bytes
         if (pos_ff == '0) begin
            magic_in = 1'b1;
            priority if (b == 8'h89) guess_in = FMT_PNG;
            else if (b == 8'hFF)     guess_in = FMT_JPEG;
            else if (b == 8'h47)     guess_in = FMT_GIF;
            else if (b == 8'h42)     guess_in = FMT_BMP;
            else                     guess_in = FMT_UNKNOWN;
         end else if (pos_ff < COUNT_BITS'(8)) begin
            unique case (guess_ff)
               FMT_PNG: begin
                  if (b != png_sig(lo[2:0])) magic_in = 1'b0;
               end
               FMT_JPEG: begin
                  if ((lo == 5'd1 && b != 8'hD8) || (lo == 5'd2 && b != 8'hFF))
                     magic_in = 1'b0;
               end
               FMT_GIF: begin
                  if (lo == 5'd4) begin
                     if (b != 8'h37 && b != 8'h39) magic_in = 1'b0;
                  end else if (lo < 5'd6 && b != gif_sig(lo[2:0])) begin
                     magic_in = 1'b0;
                  end
               end
               FMT_BMP: begin
                  if (lo == 5'd1 && b != 8'h4D) magic_in = 1'b0;
               end
               default: ;
            endcase
         end

         // Dimension capture per format
         unique case (guess_in)
            FMT_PNG: begin
               if (pos_small && lo >= 5'd12 && lo <= 5'd15 && b != ihdr_tag(lo[1:0]))
                  tag_ok_in = 1'b0;
               if (pos_small && lo >= 5'd16 && lo <= 5'd19)
                  wacc_in = lane_or(wacc_ff, ~lo[1:0], b);
               if (pos_small && lo >= 5'd20 && lo <= 5'd23)
                  hacc_in = lane_or(hacc_ff, ~lo[1:0], b);
               if (pos_small && lo == 5'd23 && tag_ok_ff)
                  dims_in = 1'b1;
            end
            FMT_GIF: begin
               if (pos_small && (lo == 5'd6 || lo == 5'd7))
                  wacc_in = lane_or(wacc_ff, {1'b0, lo[0]}, b);
               if (pos_small && (lo == 5'd8 || lo == 5'd9))
                  hacc_in = lane_or(hacc_ff, {1'b0, lo[0]}, b);
               if (pos_small && lo == 5'd9)
                  dims_in = 1'b1;
            end
            FMT_BMP: begin
               if (pos_small && lo >= 5'd18 && lo <= 5'd21)
                  wacc_in = lane_or(wacc_ff, lo[1:0] + 2'd2, b);
               if (pos_small && lo >= 5'd22 && lo <= 5'd25)
                  hacc_in = lane_or(hacc_ff, lo[1:0] + 2'd2, b);
               if (pos_small && lo == 5'd25)
                  dims_in = 1'b1;
            end
            FMT_JPEG: begin
               // Marker walker from offset 2
               if (pos_ff >= COUNT_BITS'(2)) begin
                  unique case (phase_ff)
                     WK_MARK0: phase_in = (b == 8'hFF) ? WK_MARK1 : WK_STOP;
                     WK_MARK1: begin
                        priority if (b == 8'hC0 || b == 8'hC2) phase_in = WK_SLEN0;
                        else if (b == 8'hD8 || b == 8'hD9 || b == 8'h00)
                           phase_in = WK_MARK0;
                        else phase_in = WK_LEN0;
                     end
                     WK_LEN0: begin
                        len_hi_in = b;
                        phase_in  = WK_LEN1;
                     end
                     WK_LEN1: begin
                        if (seg_len < 16'd2) begin
                           phase_in = WK_STOP;
                        end else begin
                           seg_in   = seg_len - 16'd2;
                           phase_in = (seg_len == 16'd2) ? WK_MARK0 : WK_SKIP;
                        end
                     end
                     WK_SKIP: begin
                        seg_in = seg_ff - 16'd1;
                        if (seg_ff == 16'd1) phase_in = WK_MARK0;
                     end
                     WK_SLEN0: phase_in = WK_SLEN1;
                     WK_SLEN1: phase_in = WK_PREC;
                     WK_PREC:  phase_in = WK_H0;
                     WK_H0: begin
                        hacc_in  = lane_or(hacc_ff, 2'd1, b);
                        phase_in = WK_H1;
                     end
                     WK_H1: begin
                        hacc_in  = lane_or(hacc_ff, 2'd0, b);
                        phase_in = WK_W0;
                     end
                     WK_W0: begin
                        wacc_in  = lane_or(wacc_ff, 2'd1, b);
                        phase_in = WK_W1;
                     end
                     WK_W1: begin
                        wacc_in  = lane_or(wacc_ff, 2'd0, b);
                        dims_in  = 1'b1;
                        phase_in = WK_STOP;
                     end
                     default: phase_in = WK_STOP;
                  endcase
               end
            end
            default: ;
         endcase

         // Saturating byte counter
         if (pos_ff != '1) pos_in = pos_ff + COUNT_BITS'(1);
      end
   end

   // Form the result from the updated state
   always_comb begin
      fmt_res = (pos_in >= COUNT_BITS'(8) && magic_in) ? guess_in : FMT_UNKNOWN;
      w_res   = '0;
      h_res   = '0;
      if (fmt_res != FMT_UNKNOWN && dims_in) begin
         w_res = wacc_in;
         h_res = hacc_in;
         if (fmt_res == FMT_BMP && hacc_in[31]) h_res = 32'd0 - hacc_in;
      end
      pos_wide  = WIDE_BITS'(pos_in);
      total_res = (pos_wide > WIDE_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : pos_wide[31:0];
   end

   // Hold parse state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         guess_ff     <= FMT_UNKNOWN;
         magic_ff     <= 1'b1;
         tag_ok_ff    <= 1'b1;
         wacc_ff      <= '0;
         hacc_ff      <= '0;
         phase_ff     <= WK_MARK0;
         seg_ff       <= '0;
         dims_ff      <= 1'b0;
         len_hi_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            if (req_last) begin
               pos_ff    <= '0;
               guess_ff  <= FMT_UNKNOWN;
               magic_ff  <= 1'b1;
               tag_ok_ff <= 1'b1;
               wacc_ff   <= '0;
               hacc_ff   <= '0;
               phase_ff  <= WK_MARK0;
               seg_ff    <= '0;
               dims_ff   <= 1'b0;
               len_hi_ff <= '0;
            end else begin
               pos_ff    <= pos_in;
               guess_ff  <= guess_in;
               magic_ff  <= magic_in;
               tag_ok_ff <= tag_ok_in;
               wacc_ff   <= wacc_in;
               hacc_ff   <= hacc_in;
               phase_ff  <= phase_in;
               seg_ff    <= seg_in;
               dims_ff   <= dims_in;
               len_hi_ff <= len_hi_in;
            end
         end
         if (req_accept && req_last) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)        rsp_valid_ff <= 1'b0;
      end

      // Load result payload on the last word
      if (req_accept && req_last) begin
         fmt_ff    <= fmt_res;
         recog_ff  <= (fmt_res != FMT_UNKNOWN);
         width_ff  <= w_res;
         height_ff <= h_res;
         total_ff  <= total_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_format_code  = fmt_ff;
   assign rsp_recognized   = recog_ff;
   assign rsp_image_width  = width_ff;
   assign rsp_image_height = height_ff;
   assign rsp_byte_total   = total_ff;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import ihs_pkg::*;

   // JPEG marker bytes
   localparam logic [7:0] JPEG_LEAD  = 8'hFF;
   localparam logic [7:0] JPEG_SOI   = 8'hD8;
   localparam logic [7:0] JPEG_EOI   = 8'hD9;
   localparam logic [7:0] JPEG_STUFF = 8'h00;
   localparam logic [7:0] JPEG_SOF0  = 8'hC0;
   localparam logic [7:0] JPEG_SOF2  = 8'hC2;

   localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                            8'h0D, 8'h0A, 8'h1A, 8'h0A};
   localparam logic [7:0] GIF_MAGIC [6] = '{"G", "I", "F", "8", "7", "a"};
   localparam logic [7:0] IHDR_TAG  [4] = '{"I", "H", "D", "R"};

   // Random part size per idling phase
   localparam int PHASE_BYTES = 667;
   localparam int PHASE_FILES = 20;

   typedef enum logic [3:0] {
      SEEK_FF, SEEK_CODE, LEN_HI, LEN_LO, SKIP_BODY,
      SOF_LEN_HI, SOF_LEN_LO, SOF_PREC, SOF_H_HI, SOF_H_LO, SOF_W_HI, SOF_W_LO,
      WALK_DONE
   } walk_type;

   typedef struct {
      logic [2:0]  fmt;
      logic        rec;
      logic [31:0] width;
      logic [31:0] height;
      logic [31:0] total;
   } header_info_type;

   // Header predictor and result checker
   class header_scoreboard;
      header_info_type expected_headers[$];
      longint unsigned pos;
      fmt_type         guess;
      bit              magic_ok;
      bit              tag_ok;
      bit              dims_ok;
      logic [31:0]     wacc;
      logic [31:0]     hacc;
      walk_type        walk;
      logic [15:0]     seg_left;
      logic [7:0]      len_hi;
      int              errors;
      int              words;
      int              bytes;
      int              per_format[5];

      function new();
         clear_file();
         errors = 0;
         words = 0;
         bytes = 0;
         foreach (per_format[i]) per_format[i] = 0;
      endfunction

      function void clear_file();
         pos = 0;
         guess = FMT_UNKNOWN;
         magic_ok = 1'b1;
         tag_ok = 1'b1;
         dims_ok = 1'b0;
         wacc = '0;
         hacc = '0;
         walk = SEEK_FF;
         seg_left = '0;
         len_hi = '0;
      endfunction

      function logic [31:0] with_lane(logic [31:0] acc, int lane, logic [7:0] b);
         return acc | (32'(b) << (8 * lane));
      endfunction

      // Advance the JPEG marker walker by one byte
      function void step_jpeg_walker(logic [7:0] b);
         logic [15:0] len;
         case (walk)
            SEEK_FF: walk = (b == JPEG_LEAD) ? SEEK_CODE : WALK_DONE;
            SEEK_CODE: begin
               if (b == JPEG_SOF0 || b == JPEG_SOF2)
                  walk = SOF_LEN_HI;
               else if (b == JPEG_SOI || b == JPEG_EOI || b == JPEG_STUFF)
                  walk = SEEK_FF;
               else
                  walk = LEN_HI;
            end
            LEN_HI: begin
               len_hi = b;
               walk = LEN_LO;
            end
            LEN_LO: begin
               len = {len_hi, b};
               if (len < 16'd2) begin
                  walk = WALK_DONE;
               end else begin
                  seg_left = len - 16'd2;
                  walk = (seg_left == 16'd0) ? SEEK_FF : SKIP_BODY;
               end
            end
            SKIP_BODY: begin
               seg_left = seg_left - 16'd1;
               if (seg_left == 16'd0) walk = SEEK_FF;
            end
            SOF_LEN_HI: walk = SOF_LEN_LO;
            SOF_LEN_LO: walk = SOF_PREC;
            SOF_PREC:   walk = SOF_H_HI;
            SOF_H_HI: begin
               hacc = with_lane(hacc, 1, b);
               walk = SOF_H_LO;
            end
            SOF_H_LO: begin
               hacc = with_lane(hacc, 0, b);
               walk = SOF_W_HI;
            end
            SOF_W_HI: begin
               wacc = with_lane(wacc, 1, b);
               walk = SOF_W_LO;
            end
            SOF_W_LO: begin
               wacc = with_lane(wacc, 0, b);
               dims_ok = 1'b1;
               walk = WALK_DONE;
            end
            default: walk = WALK_DONE;
         endcase
      endfunction

      // Update signature checks and dimension accumulators for one byte
      function void take_byte(logic [7:0] b);
         longint unsigned p;
         longint unsigned cmax;
         p = pos;
         cmax = (64'd1 << COUNT_BITS) - 64'd1;

         if (p == 0) begin
            magic_ok = 1'b1;
            case (b)
               8'h89:     guess = FMT_PNG;
               JPEG_LEAD: guess = FMT_JPEG;
               "G":       guess = FMT_GIF;
               "B":       guess = FMT_BMP;
               default:   guess = FMT_UNKNOWN;
            endcase
         end else if (p < 8) begin
            case (guess)
               FMT_PNG: if (b != PNG_MAGIC[p[2:0]]) magic_ok = 1'b0;
               FMT_JPEG: begin
                  if ((p == 1 && b != JPEG_SOI) || (p == 2 && b != JPEG_LEAD))
                     magic_ok = 1'b0;
               end
               FMT_GIF: begin
                  if (p == 4) begin
                     if (b != "7" && b != "9") magic_ok = 1'b0;
                  end else if (p < 6 && b != GIF_MAGIC[p[2:0]]) begin
                     magic_ok = 1'b0;
                  end
               end
               FMT_BMP: if (p == 1 && b != "M") magic_ok = 1'b0;
               default: ;
            endcase
         end

         case (guess)
            FMT_PNG: begin
               if (p >= 12 && p <= 15 && b != IHDR_TAG[p[1:0]]) tag_ok = 1'b0;
               if (p >= 16 && p <= 19) wacc = with_lane(wacc, int'(19 - p), b);
               if (p >= 20 && p <= 23) hacc = with_lane(hacc, int'(23 - p), b);
               if (p == 23 && tag_ok) dims_ok = 1'b1;
            end
            FMT_JPEG: if (p >= 2) step_jpeg_walker(b);
            FMT_GIF: begin
               if (p == 6 || p == 7) wacc = with_lane(wacc, int'(p - 6), b);
               if (p == 8 || p == 9) hacc = with_lane(hacc, int'(p - 8), b);
               if (p == 9) dims_ok = 1'b1;
            end
            FMT_BMP: begin
               if (p >= 18 && p <= 21) wacc = with_lane(wacc, int'(p - 18), b);
               if (p >= 22 && p <= 25) hacc = with_lane(hacc, int'(p - 22), b);
               if (p == 25) dims_ok = 1'b1;
            end
            default: ;
         endcase

         if (p < cmax) pos = p + 1;
      endfunction

      // Note an accepted input word
      function void note_word(logic [7:0] b, logic has, logic fin);
         header_info_type r;
         words++;
         if (has) begin
            bytes++;
            take_byte(b);
         end
         if (fin) begin
            r.fmt = (pos >= 8 && magic_ok) ? guess : FMT_UNKNOWN;
            r.rec = (r.fmt != FMT_UNKNOWN);
            r.width = '0;
            r.height = '0;
            if (r.fmt != FMT_UNKNOWN && dims_ok) begin
               r.width = wacc;
               r.height = hacc;
               if (r.fmt == FMT_BMP && r.height[31]) r.height = -r.height;
            end
            r.total = (pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos[31:0];
            per_format[r.fmt]++;
            expected_headers.push_back(r);
            clear_file();
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
         if (act !== exp) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
            errors++;
         end
      endfunction

      // Check one accepted result word against the oldest expectation
      function void check_result(logic [2:0] fmt, logic rec, logic [31:0] width,
                                 logic [31:0] height, logic [31:0] total);
         header_info_type r;
         if (expected_headers.size() == 0) begin
            $error("unexpected result: format_code 0x%0h, byte_total 0x%0h", fmt, total);
            errors++;
         end else begin
            r = expected_headers.pop_front();
            compare_field("format_code", 32'(r.fmt), 32'(fmt));
            compare_field("recognized", 32'(r.rec), 32'(rec));
            compare_field("image_width", r.width, width);
            compare_field("image_height", r.height, height);
            compare_field("byte_total", r.total, total);
         end
      endfunction

      function int pending();
         return expected_headers.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_has_byte = 1'b0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_format_code;
   logic               rsp_recognized;
   logic signed [31:0] rsp_image_width;
   logic signed [31:0] rsp_image_height;
   logic [31:0]        rsp_byte_total;

   header_scoreboard sb = new();
   logic [7:0]       file_q[$];
   int               send_idle_pct = 16;
   int               recv_stall_pct = 51;
   int               bytes_sent = 0;
   int               files_sent = 0;

   image_header_sniffer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_format_code  (rsp_format_code),
      .rsp_recognized   (rsp_recognized),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_byte_total   (rsp_byte_total)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_format_code, rsp_recognized, rsp_image_width,
                         rsp_image_height, rsp_byte_total);
   end

   // Present one word, hold it until accepted
   task automatic send_word(input logic [7:0] b, input logic has, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_has_byte <= has;
      req_last <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(b, has, fin);
      @(negedge clock);
   endtask

   // Stream the current file, closing it on its last byte or by an empty word
   task automatic send_file(input bit split_end);
      int n;
      n = file_q.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 3) send_word(8'($urandom), 1'b0, 1'b0);
         send_word(file_q[i], 1'b1, (i == n - 1) && !split_end);
      end
      if (split_end || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
      bytes_sent += n;
      files_sent++;
   endtask

   function automatic logic [31:0] pick_dim32();
      case ($urandom_range(5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'($urandom_range(1, 4096));
         default: return 32'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_dim16();
      case ($urandom_range(5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'($urandom_range(1, 2048));
         default: return 16'($urandom);
      endcase
   endfunction

   // Any marker code that carries a length field, frame headers apart
   function automatic logic [7:0] pick_segment_code();
      logic [7:0] c;
      do begin
         c = 8'($urandom);
      end while (c == JPEG_SOF0 || c == JPEG_SOF2 || c == JPEG_SOI ||
                 c == JPEG_EOI || c == JPEG_STUFF);
      return c;
   endfunction

   task automatic push_be(input logic [31:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) file_q.push_back(v[8 * i +: 8]);
   endtask

   task automatic push_le(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++) file_q.push_back(v[8 * i +: 8]);
   endtask

   task automatic push_rand(input int n);
      for (int i = 0; i < n; i++) file_q.push_back(8'($urandom));
   endtask

   task automatic build_png();
      foreach (PNG_MAGIC[i]) file_q.push_back(PNG_MAGIC[i]);
      push_be(($urandom_range(3) == 0) ? 32'($urandom) : 32'd13, 4);
      foreach (IHDR_TAG[i]) file_q.push_back(IHDR_TAG[i]);
      push_be(pick_dim32(), 4);
      push_be(pick_dim32(), 4);
      push_rand($urandom_range(0, 8));
   endtask

   task automatic build_gif();
      file_q.push_back("G");
      file_q.push_back("I");
      file_q.push_back("F");
      file_q.push_back("8");
      file_q.push_back($urandom_range(1) ? "7" : "9");
      file_q.push_back("a");
      push_le(32'(pick_dim16()), 2);
      push_le(32'(pick_dim16()), 2);
      push_rand($urandom_range(0, 10));
   endtask

   task automatic build_bmp();
      file_q.push_back("B");
      file_q.push_back("M");
      push_rand(16);
      push_le(pick_dim32(), 4);
      push_le(pick_dim32(), 4);
      push_rand($urandom_range(0, 6));
   endtask

   // Marker sequence with random segments, mostly ending in a frame header
   task automatic build_jpeg();
      int nseg;
      int len;
      file_q.push_back(JPEG_LEAD);
      file_q.push_back(JPEG_SOI);
      nseg = $urandom_range(0, 3);
      for (int k = 0; k < nseg; k++) begin
         case ($urandom_range(9))
            0, 1: begin
               file_q.push_back(JPEG_LEAD);
               case ($urandom_range(2))
                  0:       file_q.push_back(JPEG_SOI);
                  1:       file_q.push_back(JPEG_EOI);
                  default: file_q.push_back(JPEG_STUFF);
               endcase
            end
            2: begin
               if ($urandom_range(1)) begin
                  file_q.push_back(8'($urandom_range(0, 8'hFE)));
               end else begin
                  file_q.push_back(JPEG_LEAD);
                  file_q.push_back(pick_segment_code());
                  push_be(32'($urandom_range(0, 1)), 2);
               end
            end
            default: begin
               len = ($urandom_range(39) == 0) ? $urandom_range(2, 600)
                                               : $urandom_range(2, 12);
               file_q.push_back(JPEG_LEAD);
               file_q.push_back(pick_segment_code());
               push_be(32'(len), 2);
               push_rand(len - 2);
            end
         endcase
      end
      if ($urandom_range(3) != 0) begin
         file_q.push_back(JPEG_LEAD);
         file_q.push_back($urandom_range(1) ? JPEG_SOF0 : JPEG_SOF2);
         push_rand(3);
         push_be(32'(pick_dim16()), 2);
         push_be(32'(pick_dim16()), 2);
         push_rand($urandom_range(0, 6));
      end else begin
         push_rand($urandom_range(0, 4));
      end
   endtask

   // Flip a byte or cut the file short now and then
   task automatic mangle_file();
      int keep;
      if (file_q.size() > 0 && $urandom_range(99) < 12)
         file_q[$urandom_range(0, file_q.size() - 1)] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(99) < 12) begin
         keep = $urandom_range(0, file_q.size());
         while (file_q.size() > keep) void'(file_q.pop_back());
      end
   endtask

   task automatic send_random_file();
      file_q.delete();
      case ($urandom_range(9))
         0, 1:    build_png();
         2, 3, 4: build_jpeg();
         5, 6:    build_gif();
         7:       build_bmp();
         default: begin
            push_rand($urandom_range(0, 30));
            if (file_q.size() > 0 && $urandom_range(1)) begin
               case ($urandom_range(3))
                  0:       file_q[0] = PNG_MAGIC[0];
                  1:       file_q[0] = JPEG_LEAD;
                  2:       file_q[0] = "G";
                  default: file_q[0] = "B";
               endcase
            end
         end
      endcase
      mangle_file();
      send_file($urandom_range(9) == 0);
   endtask

   initial begin
      int start_bytes;
      int start_files;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Empty file, idle word, then a file too short to classify
      file_q.delete();
      send_file(1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      file_q = '{"G", "I", "F"};
      send_file(1'b0);

      // GIF with widest width and zero height
      file_q = '{"G", "I", "F", "8", "9", "a", 8'hFF, 8'hFF, 8'h00, 8'h00};
      send_file(1'b0);

      // Minimal progressive JPEG frame header right after the start marker
      file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hC2, 8'h00, 8'h11, 8'h08,
                 8'hFF, 8'hFF, 8'h00, 8'h00};
      send_file(1'b0);

      // Random files across three idling mixes
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 16;
               recv_stall_pct = 51;
            end
            1: begin
               send_idle_pct = 51;
               recv_stall_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         start_bytes = bytes_sent;
         start_files = files_sent;
         while (bytes_sent - start_bytes < PHASE_BYTES ||
                files_sent - start_files < PHASE_FILES)
            send_random_file();
      end
      req_valid <= 1'b0;

      // Drain outstanding results
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Streamed %0d files in %0d words (%0d data bytes).",
               files_sent, sb.words, sb.bytes);
      $display("Results by format: unknown %0d, PNG %0d, JPEG %0d, GIF %0d, BMP %0d.",
               sb.per_format[0], sb.per_format[1], sb.per_format[2],
               sb.per_format[3], sb.per_format[4]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
